### sv/axft_pkg.sv
//------------------------------------------------------------------------------
// axft_pkg: shared types and constants for the two-point axis pipeline
// Coordinate format, internal datapath widths and the channel payload structs.
//------------------------------------------------------------------------------
`default_nettype none

package axft_pkg;

	localparam int COORD_WIDTH = 32;

	// Difference of two coordinates and the normalization window.
	localparam int DIFF_W   = COORD_WIDTH + 1;
	localparam int NORM_W   = 31;
	localparam int NORM_TOP = NORM_W - 1;
	localparam int EXT_W    = DIFF_W + NORM_W;
	localparam int SH_W     = $clog2(EXT_W);

	// Sum of squares and its integer square root.
	localparam int SQP_W      = 2 * NORM_W;
	localparam int SQ_W       = 2 * NORM_W + 2;
	localparam int ROOT_W     = NORM_W + 1;
	localparam int ROOT_STEPS = SQ_W / 2;

	// Unit vector in Q2.30 and the divider that produces it.
	localparam int Q_FRAC  = 30;
	localparam int QUO_W   = NORM_W;
	localparam int REM_W   = NORM_W + Q_FRAC + 2;
	localparam int DIR_W   = 32;
	localparam int UMAG_W  = Q_FRAC + 1;

	// Projection of the first point onto the direction.
	localparam int PM_LO  = COORD_WIDTH / 2;
	localparam int PM_HI  = COORD_WIDTH - PM_LO;
	localparam int DPL_W  = PM_LO + UMAG_W;
	localparam int DPH_W  = PM_HI + UMAG_W;
	localparam int DF_W   = COORD_WIDTH + UMAG_W + 1;
	localparam int TERM_W = COORD_WIDTH + 2;
	localparam int DOT_W  = COORD_WIDTH + 3;
	localparam int DMAG_W = DOT_W - 1;
	localparam int DM_LO  = DMAG_W / 2;
	localparam int DM_HI  = DMAG_W - DM_LO;
	localparam int PPL_W  = DM_LO + UMAG_W;
	localparam int PPH_W  = DM_HI + UMAG_W;
	localparam int PF_W   = DMAG_W + UMAG_W + 1;
	localparam int PROJ_W = COORD_WIDTH + 3;
	localparam int CEN_W  = COORD_WIDTH + 4;

	localparam logic [DIR_W-1:0] DIR_ONE = DIR_W'(64'd1 << Q_FRAC);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIR_W-1:0] dir_t;

	typedef logic [2:0][NORM_W-1:0] norm3_t;
	typedef logic [2:0][REM_W-1:0] rem3_t;
	typedef logic [2:0][QUO_W-1:0] quo3_t;
	typedef logic [2:0][DIR_W-1:0] dir3_t;

	// Values that ride along with the arithmetic through the pipeline.
	typedef struct packed {
		logic [2:0][COORD_WIDTH-1:0] p1;
		logic [2:0] sgn;
		logic degen;
	} side_t;

	typedef struct packed {
		coord_t p1_x;
		coord_t p1_y;
		coord_t p1_z;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p2_z;
	} pts_t;

	typedef struct packed {
		dir_t dir_x;
		dir_t dir_y;
		dir_t dir_z;
		coord_t center_x;
		coord_t center_y;
		coord_t center_z;
		logic degenerate;
	} axis_t;

endpackage

`default_nettype wire

### sv/axis_from_two_points.sv
// Throughput: one point pair per cycle when not stalled; the square root (32
// stages) and three dividers (31 stages each) resolve one result bit per stage.
// Reset clears the stage valid bits and the skid register's full flag only.
// The input stalls only while the skid register holds a result.
//------------------------------------------------------------------------------
// axis_from_two_points: canonical axis through two 3-D points
// Computes the unit direction (Q2.30, lower point to higher point) and the
// axis point nearest the origin, saturated, in a fully pipelined datapath.
//------------------------------------------------------------------------------
`default_nettype none

module axis_from_two_points (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pts_valid,
	output logic            pts_stall,
	input  axft_pkg::pts_t  pts,
	output logic            axis_valid,
	input  logic            axis_stall,
	output axft_pkg::axis_t axis
);
	import axft_pkg::*;

	localparam int NSTG = 6 + ROOT_STEPS + 1 + QUO_W + 1 + 3 + 3;

	logic en;
	logic [NSTG-1:0] stg_vld_s;
	logic skid_q;
	axis_t skid_data_q;

	// Stage 1: differences
	logic [COORD_WIDTH-1:0] p1_s1 [3];
	logic signed [DIFF_W-1:0] d_s1 [3];

	// Stage 2: orientation and magnitudes
	logic [2:0] nz_c;
	logic neg_c;
	logic [DIFF_W-1:0] mag_c [3];
	side_t side_s2;
	logic [DIFF_W-1:0] mag_s2 [3];

	// Stage 3: common shift amount
	logic [DIFF_W-1:0] or_c;
	logic [SH_W-1:0] pos_c;
	side_t side_s3;
	logic [DIFF_W-1:0] mag_s3 [3];
	logic rsh_s3;
	logic [SH_W-1:0] amt_s3;

	// Stage 4: normalized magnitudes
	logic [EXT_W-1:0] shf_c [3];
	side_t side_s4;
	norm3_t norm_s4;

	// Stages 5 and 6: squares and their sum
	logic [SQP_W-1:0] sq_s5 [3];
	side_t side_s5;
	norm3_t norm_s5;
	logic [SQ_W-1:0] sum_s6;
	side_t side_s6;
	norm3_t norm_s6;

	// Square root stages
	logic [SQ_W-1:0] rt_v_s [ROOT_STEPS];
	logic [SQ_W-1:0] rt_r_s [ROOT_STEPS];
	side_t rt_side_s [ROOT_STEPS];
	norm3_t rt_norm_s [ROOT_STEPS];

	// Divider stages, entry 0 holds the prepared dividends
	logic [ROOT_W-1:0] n_c;
	logic [ROOT_W-1:0] dv_n_s [QUO_W+1];
	rem3_t dv_rem_s [QUO_W+1];
	quo3_t dv_q_s [QUO_W+1];
	side_t dv_side_s [QUO_W+1];

	// Direction assembly
	dir3_t dir_c;
	dir3_t dir_s;
	side_t side_d_s;

	// Dot product of the first point with the direction
	logic [COORD_WIDTH-1:0] pm_c [3];
	logic [UMAG_W-1:0] du_c [3];
	logic [DPL_W-1:0] da_pl_s [3];
	logic [DPH_W-1:0] da_ph_s [3];
	logic [2:0] da_sg_s;
	dir3_t dir_a_s;
	side_t side_a_s;
	logic [DF_W-1:0] dfull_c [3];
	logic signed [TERM_W-1:0] term_s [3];
	dir3_t dir_b_s;
	side_t side_b_s;
	logic signed [DOT_W-1:0] dot_s;
	dir3_t dir_cc_s;
	side_t side_cc_s;

	// Projection back onto the direction, then the center
	logic [DMAG_W-1:0] dm_c;
	logic [UMAG_W-1:0] pu_c [3];
	logic [PPL_W-1:0] pa_pl_s [3];
	logic [PPH_W-1:0] pa_ph_s [3];
	logic [2:0] pa_sg_s;
	dir3_t dir_pa_s;
	side_t side_pa_s;
	logic [PF_W-1:0] pfull_c [3];
	logic signed [PROJ_W-1:0] proj_s [3];
	dir3_t dir_pb_s;
	side_t side_pb_s;
	logic signed [CEN_W-1:0] cen_c [3];
	logic [COORD_WIDTH-1:0] sat_c [3];
	logic [CEN_W-COORD_WIDTH:0] top_c [3];
	axis_t fin_s;

	//--------------------------------------------------------------------------
	// Flow control: the whole pipeline advances unless the skid register is full.
	//--------------------------------------------------------------------------
	assign en = !skid_q;
	assign pts_stall = skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_s <= '0;
		end else if (en) begin
			stg_vld_s <= {stg_vld_s[NSTG-2:0], pts_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (!axis_stall) begin
				skid_q <= 1'b0;
			end
		end else if (stg_vld_s[NSTG-1] && axis_stall) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			skid_data_q <= fin_s;
		end
	end

	assign axis_valid = skid_q | stg_vld_s[NSTG-1];
	assign axis = skid_q ? skid_data_q : fin_s;

	//--------------------------------------------------------------------------
	// Stage 1
	//--------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1[0] <= pts.p1_x;
			p1_s1[1] <= pts.p1_y;
			p1_s1[2] <= pts.p1_z;
			d_s1[0] <= DIFF_W'(pts.p2_x) - DIFF_W'(pts.p1_x);
			d_s1[1] <= DIFF_W'(pts.p2_y) - DIFF_W'(pts.p1_y);
			d_s1[2] <= DIFF_W'(pts.p2_z) - DIFF_W'(pts.p1_z);
		end
	end

	//--------------------------------------------------------------------------
	// Stage 2: the first nonzero component in z, y, x order must be positive.
	//--------------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nz_c[i] = (d_s1[i] != '0);
			mag_c[i] = d_s1[i][DIFF_W-1] ? (DIFF_W'(0) - DIFF_W'(d_s1[i])) : DIFF_W'(d_s1[i]);
		end
		if (nz_c[2]) begin
			neg_c = d_s1[2][DIFF_W-1];
		end else if (nz_c[1]) begin
			neg_c = d_s1[1][DIFF_W-1];
		end else begin
			neg_c = d_s1[0][DIFF_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				side_s2.p1[i] <= p1_s1[i];
				side_s2.sgn[i] <= d_s1[i][DIFF_W-1] ^ neg_c;
				mag_s2[i] <= mag_c[i];
			end
			side_s2.degen <= ~|nz_c;
		end
	end

	//--------------------------------------------------------------------------
	// Stage 3: the leading one of the largest magnitude is that of the OR.
	//--------------------------------------------------------------------------
	always_comb begin
		or_c = mag_s2[0] | mag_s2[1] | mag_s2[2];
		pos_c = '0;
		for (int i = 0; i < DIFF_W; i++) begin
			if (or_c[i]) begin
				pos_c = SH_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			mag_s3 <= mag_s2;
			rsh_s3 <= (pos_c > SH_W'(NORM_TOP));
			amt_s3 <= (pos_c > SH_W'(NORM_TOP)) ? (pos_c - SH_W'(NORM_TOP))
				: (SH_W'(NORM_TOP) - pos_c);
		end
	end

	//--------------------------------------------------------------------------
	// Stage 4: bring the largest magnitude into [2^30, 2^31).
	//--------------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shf_c[i] = rsh_s3 ? (EXT_W'(mag_s3[i]) >> amt_s3) : (EXT_W'(mag_s3[i]) << amt_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			for (int i = 0; i < 3; i++) begin
				norm_s4[i] <= shf_c[i][NORM_W-1:0];
			end
		end
	end

	//--------------------------------------------------------------------------
	// Stages 5 and 6: sum of squares
	//--------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			norm_s5 <= norm_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= SQP_W'(norm_s4[i]) * SQP_W'(norm_s4[i]);
			end
			side_s6 <= side_s5;
			norm_s6 <= norm_s5;
			sum_s6 <= SQ_W'(sq_s5[0]) + SQ_W'(sq_s5[1]) + SQ_W'(sq_s5[2]);
		end
	end

	//--------------------------------------------------------------------------
	// Integer square root, one result bit per stage.
	//--------------------------------------------------------------------------
	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W-1:0] v_in;
		logic [SQ_W-1:0] r_in;
		logic [SQ_W-1:0] trial;
		side_t side_in;
		norm3_t norm_in;

		if (k == 0) begin : g_first
			assign v_in = sum_s6;
			assign r_in = '0;
			assign side_in = side_s6;
			assign norm_in = norm_s6;
		end else begin : g_next
			assign v_in = rt_v_s[k-1];
			assign r_in = rt_r_s[k-1];
			assign side_in = rt_side_s[k-1];
			assign norm_in = rt_norm_s[k-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= trial) begin
					rt_v_s[k] <= v_in - trial;
					rt_r_s[k] <= (r_in >> 1) + BIT;
				end else begin
					rt_v_s[k] <= v_in;
					rt_r_s[k] <= r_in >> 1;
				end
				rt_side_s[k] <= side_in;
				rt_norm_s[k] <= norm_in;
			end
		end
	end

	//--------------------------------------------------------------------------
	// Dividends a * 2^30 + n / 2, rounding the quotient to nearest.
	//--------------------------------------------------------------------------
	assign n_c = rt_r_s[ROOT_STEPS-1][ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_n_s[0] <= n_c;
			dv_side_s[0] <= rt_side_s[ROOT_STEPS-1];
			dv_q_s[0] <= '0;
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= (REM_W'(rt_norm_s[ROOT_STEPS-1][i]) << Q_FRAC)
					+ REM_W'(n_c >> 1);
			end
		end
	end

	// Restoring division, three lanes sharing one divisor, one bit per stage.
	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int SH = QUO_W - 1 - j;
		logic [REM_W-1:0] cmp;
		rem3_t rem_nx;
		quo3_t q_nx;

		assign cmp = REM_W'(dv_n_s[j]) << SH;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				if (dv_rem_s[j][i] >= cmp) begin
					rem_nx[i] = dv_rem_s[j][i] - cmp;
					q_nx[i] = dv_q_s[j][i] | (QUO_W'(1) << SH);
				end else begin
					rem_nx[i] = dv_rem_s[j][i];
					q_nx[i] = dv_q_s[j][i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_n_s[j+1] <= dv_n_s[j];
				dv_side_s[j+1] <= dv_side_s[j];
				dv_rem_s[j+1] <= rem_nx;
				dv_q_s[j+1] <= q_nx;
			end
		end
	end

	//--------------------------------------------------------------------------
	// Signed direction; coincident points give +z.
	//--------------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir_c[i] = dv_side_s[QUO_W].sgn[i] ? (DIR_W'(0) - DIR_W'(dv_q_s[QUO_W][i]))
				: DIR_W'(dv_q_s[QUO_W][i]);
		end
		if (dv_side_s[QUO_W].degen) begin
			dir_c[0] = '0;
			dir_c[1] = '0;
			dir_c[2] = DIR_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s <= dir_c;
			side_d_s <= dv_side_s[QUO_W];
		end
	end

	//--------------------------------------------------------------------------
	// Dot product: split partial products, then round each term.
	//--------------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pm_c[i] = side_d_s.p1[i][COORD_WIDTH-1] ? (COORD_WIDTH'(0) - side_d_s.p1[i])
				: side_d_s.p1[i];
			du_c[i] = dir_s[i][DIR_W-1] ? UMAG_W'(DIR_W'(0) - dir_s[i]) : UMAG_W'(dir_s[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				da_pl_s[i] <= DPL_W'(pm_c[i][PM_LO-1:0]) * DPL_W'(du_c[i]);
				da_ph_s[i] <= DPH_W'(pm_c[i][COORD_WIDTH-1:PM_LO]) * DPH_W'(du_c[i]);
				da_sg_s[i] <= side_d_s.p1[i][COORD_WIDTH-1] ^ dir_s[i][DIR_W-1];
			end
			dir_a_s <= dir_s;
			side_a_s <= side_d_s;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dfull_c[i] = (DF_W'(da_ph_s[i]) << PM_LO) + DF_W'(da_pl_s[i])
				+ (DF_W'(1) << (Q_FRAC - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				term_s[i] <= da_sg_s[i] ? (TERM_W'(0) - dfull_c[i][Q_FRAC +: TERM_W])
					: dfull_c[i][Q_FRAC +: TERM_W];
			end
			dir_b_s <= dir_a_s;
			side_b_s <= side_a_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s <= DOT_W'(term_s[0]) + DOT_W'(term_s[1]) + DOT_W'(term_s[2]);
			dir_cc_s <= dir_b_s;
			side_cc_s <= side_b_s;
		end
	end

	//--------------------------------------------------------------------------
	// Projection of the dot product onto each direction component.
	//--------------------------------------------------------------------------
	always_comb begin
		dm_c = dot_s[DOT_W-1] ? DMAG_W'(DOT_W'(0) - dot_s) : DMAG_W'(dot_s);
		for (int i = 0; i < 3; i++) begin
			pu_c[i] = dir_cc_s[i][DIR_W-1] ? UMAG_W'(DIR_W'(0) - dir_cc_s[i])
				: UMAG_W'(dir_cc_s[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_pl_s[i] <= PPL_W'(dm_c[DM_LO-1:0]) * PPL_W'(pu_c[i]);
				pa_ph_s[i] <= PPH_W'(dm_c[DMAG_W-1:DM_LO]) * PPH_W'(pu_c[i]);
				pa_sg_s[i] <= dot_s[DOT_W-1] ^ dir_cc_s[i][DIR_W-1];
			end
			dir_pa_s <= dir_cc_s;
			side_pa_s <= side_cc_s;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pfull_c[i] = (PF_W'(pa_ph_s[i]) << DM_LO) + PF_W'(pa_pl_s[i])
				+ (PF_W'(1) << (Q_FRAC - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				proj_s[i] <= pa_sg_s[i] ? (PROJ_W'(0) - pfull_c[i][Q_FRAC +: PROJ_W])
					: pfull_c[i][Q_FRAC +: PROJ_W];
			end
			dir_pb_s <= dir_pa_s;
			side_pb_s <= side_pa_s;
		end
	end

	//--------------------------------------------------------------------------
	// Center with saturation to the coordinate range.
	//--------------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cen_c[i] = CEN_W'($signed(side_pb_s.p1[i])) - CEN_W'(proj_s[i]);
			top_c[i] = cen_c[i][CEN_W-1:COORD_WIDTH-1];
			if ((&top_c[i]) || !(|top_c[i])) begin
				sat_c[i] = cen_c[i][COORD_WIDTH-1:0];
			end else if (cen_c[i][CEN_W-1]) begin
				sat_c[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
			end else begin
				sat_c[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s.dir_x <= dir_pb_s[0];
			fin_s.dir_y <= dir_pb_s[1];
			fin_s.dir_z <= dir_pb_s[2];
			fin_s.center_x <= sat_c[0];
			fin_s.center_y <= sat_c[1];
			fin_s.center_z <= sat_c[2];
			fin_s.degenerate <= side_pb_s.degen;
		end
	end

endmodule

`default_nettype wire

### verif/axis_checker.sv
//------------------------------------------------------------------------------
// axis_checker: prediction and comparison for the two-point axis pipeline
// Watches both channels, computes the expected axis for every accepted point
// pair and compares each accepted result field by field with the oldest one.
//------------------------------------------------------------------------------
module axis_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pts_valid,
	input  logic            pts_stall,
	input  axft_pkg::pts_t  pts,
	input  logic            axis_valid,
	input  logic            axis_stall,
	input  axft_pkg::axis_t axis,
	output int              errors,
	output int              waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import axft_pkg::*;

	axis_t pending_axes[$];

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// Rounded product of a magnitude and a Q2.30 factor, halves away from zero.
	function automatic logic [63:0] round_q30(logic [63:0] m, logic [63:0] u);
		logic [63:0] hi;
		logic [63:0] lo;
		hi = m >> 30;
		lo = m & 64'h3FFF_FFFF;
		return hi * u + ((lo * u + (64'd1 << 29)) >> 30);
	endfunction

	function automatic longint scaled(longint v, longint u);
		longint m;
		m = longint'(round_q30(magnitude(v), magnitude(u)));
		return ((v < 0) != (u < 0)) ? -m : m;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic axis_t axis_of_points(pts_t p);
		longint      p1[3];
		longint      d[3];
		longint      dir[3];
		logic [63:0] a[3];
		logic [63:0] largest;
		logic [63:0] norm;
		logic [63:0] sumsq;
		longint      dotp;
		longint      c;
		longint      cen[3];
		int          lead;
		axis_t       r;
		p1[0] = p.p1_x;
		p1[1] = p.p1_y;
		p1[2] = p.p1_z;
		d[0] = longint'(p.p2_x) - p1[0];
		d[1] = longint'(p.p2_y) - p1[1];
		d[2] = longint'(p.p2_z) - p1[2];
		lead = -1;
		for (int i = 2; i >= 0; i--)
			if (lead < 0 && d[i] != 0)
				lead = i;
		if (lead < 0) begin
			dir[0] = 0;
			dir[1] = 0;
			dir[2] = longint'(1) << 30;
		end else begin
			if (d[lead] < 0)
				for (int i = 0; i < 3; i++)
					d[i] = -d[i];
			largest = 0;
			for (int i = 0; i < 3; i++) begin
				a[i] = magnitude(d[i]);
				if (a[i] > largest)
					largest = a[i];
			end
			// One common shift brings the largest magnitude into [2^30, 2^31).
			while (largest >= (64'd1 << 31)) begin
				largest >>= 1;
				for (int i = 0; i < 3; i++)
					a[i] >>= 1;
			end
			while (largest < (64'd1 << 30)) begin
				largest <<= 1;
				for (int i = 0; i < 3; i++)
					a[i] <<= 1;
			end
			sumsq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
			norm = floor_sqrt(sumsq);
			for (int i = 0; i < 3; i++) begin
				c = longint'(((a[i] << 30) + (norm >> 1)) / norm);
				dir[i] = d[i] < 0 ? -c : c;
			end
		end
		dotp = 0;
		for (int i = 0; i < 3; i++)
			dotp += scaled(p1[i], dir[i]);
		for (int i = 0; i < 3; i++) begin
			c = p1[i] - scaled(dotp, dir[i]);
			if (c > 64'sd2147483647)
				c = 64'sd2147483647;
			if (c < -64'sd2147483648)
				c = -64'sd2147483648;
			cen[i] = c;
		end
		r.dir_x = dir_t'(dir[0]);
		r.dir_y = dir_t'(dir[1]);
		r.dir_z = dir_t'(dir[2]);
		r.center_x = coord_t'(cen[0]);
		r.center_y = coord_t'(cen[1]);
		r.center_z = coord_t'(cen[2]);
		r.degenerate = (lead < 0);
		return r;
	endfunction

	task automatic compare_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		waiting = 0;
	end

	always @(posedge clk) begin
		axis_t want;
		if (arst_n) begin
			if (axis_valid && !axis_stall) begin
				if (pending_axes.size() == 0) begin
					$error("axis transaction with no point pair outstanding");
					errors++;
				end else begin
					want = pending_axes.pop_front();
					compare_field("dir_x", want.dir_x, axis.dir_x);
					compare_field("dir_y", want.dir_y, axis.dir_y);
					compare_field("dir_z", want.dir_z, axis.dir_z);
					compare_field("center_x", want.center_x, axis.center_x);
					compare_field("center_y", want.center_y, axis.center_y);
					compare_field("center_z", want.center_z, axis.center_z);
					compare_field("degenerate", want.degenerate, axis.degenerate);
				end
			end
			if (pts_valid && !pts_stall)
				pending_axes.push_back(axis_of_points(pts));
			waiting = pending_axes.size();
		end
	end

endmodule

### verif/tb_axis_from_two_points.sv
//------------------------------------------------------------------------------
// tb_axis_from_two_points: testbench for the two-point axis pipeline
// Drives directed and random point pairs with random gaps and output stalls,
// including one long output hold-off that backs the pipeline up to its input.
//------------------------------------------------------------------------------
module tb_axis_from_two_points;
	timeunit 1ns;
	timeprecision 1ps;

	import axft_pkg::*;

	localparam int RANDOM_PAIRS = 1680;
	localparam coord_t CMAX = 32'sh7FFF_FFFF;
	localparam coord_t CMIN = 32'sh8000_0000;

	logic  clk;
	logic  arst_n;
	logic  pts_valid;
	logic  pts_stall;
	pts_t  pts;
	logic  axis_valid;
	logic  axis_stall;
	axis_t axis;
	int    errors;
	int    waiting;
	int    pairs_sent;
	bit    hold_done;

	axis_from_two_points dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pts_valid  (pts_valid),
		.pts_stall  (pts_stall),
		.pts        (pts),
		.axis_valid (axis_valid),
		.axis_stall (axis_stall),
		.axis       (axis)
	);

	axis_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pts_valid  (pts_valid),
		.pts_stall  (pts_stall),
		.pts        (pts),
		.axis_valid (axis_valid),
		.axis_stall (axis_stall),
		.axis       (axis),
		.errors     (errors),
		.waiting    (waiting)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(3, 1);
		return $urandom_range(60, 20);
	endfunction

	// Holds the pair on the channel until it is taken, then opens a random gap, possibly none.
	task automatic send_pair(coord_t ax, coord_t ay, coord_t az,
			coord_t bx, coord_t by, coord_t bz);
		int gap;
		pts_valid <= 1'b1;
		pts <= '{p1_x: ax, p1_y: ay, p1_z: az, p2_x: bx, p2_y: by, p2_z: bz};
		do
			@(posedge clk);
		while (pts_stall);
		pairs_sent++;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			pts_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	function automatic coord_t random_coord(int style);
		case (style)
			0: return coord_t'($urandom());
			1: return coord_t'($urandom_range(2000)) - 1000;
			2: return $urandom_range(1) ? CMAX - coord_t'($urandom_range(3))
				: CMIN + coord_t'($urandom_range(3));
			default: return coord_t'($urandom()) >>> $urandom_range(31);
		endcase
	endfunction

	task automatic send_random_pair();
		coord_t a[3];
		coord_t b[3];
		int style;
		int roll;
		style = $urandom_range(3);
		for (int i = 0; i < 3; i++) begin
			a[i] = random_coord(style);
			b[i] = random_coord($urandom_range(1) ? style : $urandom_range(3));
		end
		roll = $urandom_range(19);
		if (roll == 0) begin
			b = a;
		end else if (roll < 4) begin
			// Points that differ along at most one axis.
			b = a;
			b[$urandom_range(2)] = random_coord(style);
		end
		send_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
	endtask

	// Receiver: random stalls, one long hold-off while the sender keeps going, and a stall-free stretch.
	initial begin
		axis_stall = 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && pairs_sent >= 400) begin
				hold_done = 1;
				axis_stall <= 1'b1;
				repeat (400)
					@(negedge clk);
				axis_stall <= 1'b0;
			end else if (pairs_sent >= 1200 && pairs_sent < 1400) begin
				axis_stall <= 1'b0;
			end else begin
				axis_stall <= ($urandom_range(99) < 25);
			end
		end
	end

	initial begin
		#5ms;
		$display("tb_axis_from_two_points: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		pts_valid = 1'b0;
		pts = '0;
		pairs_sent = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(CMAX, CMIN, CMAX, CMAX, CMIN, CMAX);
		send_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
		send_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
		send_pair(0, 0, 0, 1, 0, 0);
		send_pair(0, 0, 0, -1, 0, 0);
		send_pair(0, 0, 0, 0, 1, 0);
		send_pair(0, 0, 0, 0, -1, 0);
		send_pair(0, 0, 0, 0, 0, 1);
		send_pair(0, 0, 0, 0, 0, -1);
		send_pair(CMAX, CMAX, 0, CMAX - 1, CMAX + 0 - 0, 0);
		send_pair(CMAX, CMIN, 0, CMIN, CMAX, 0);
		send_pair(CMAX, CMAX, 0, CMIN, CMIN, 0);
		send_pair(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
		send_pair(CMAX, CMAX, CMAX, CMAX - 1, CMAX + 0, CMAX - 1);
		send_pair(CMIN, 0, 0, CMAX, 1, 0);
		send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMIN);
		send_pair(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
			32'sh0004_0000, 32'sh0006_0000, 32'sh0003_0000);
		send_pair(-5, 7, 9, -5, 7, 9);
		send_pair(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);

		repeat (RANDOM_PAIRS)
			send_random_pair();
		pts_valid <= 1'b0;

		wait (waiting == 0);
		repeat (150)
			@(posedge clk);
		if (errors == 0)
			$display("tb_axis_from_two_points: clean");
		else
			$display("tb_axis_from_two_points: errors");
		$finish;
	end

endmodule

### files.f
sv/axft_pkg.sv
sv/axis_from_two_points.sv
verif/axis_checker.sv
verif/tb_axis_from_two_points.sv
